@@ sv/nbf_pkg.sv @@
`timescale 1ns / 1ps
// Package: shared constants and controller/datapath interface types for the 3x3 filter.
package nbf_pkg;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 13;
    localparam int IN_PIX_W   = 16;
    localparam int ROW_W      = 14;
    localparam int DIVISOR_W  = 5;

    localparam logic [CFG_IDX_W-1:0] CFG_MODE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 2'd2;

    localparam logic [1:0] MODE_BOX   = 2'd0;
    localparam logic [1:0] MODE_GAUSS = 2'd1;
    localparam logic [1:0] MODE_FILL  = 2'd2;

    localparam logic [8:0]  WIDTH_RESET  = 9'd256;
    localparam logic [12:0] HEIGHT_RESET = 13'd156;

    typedef struct packed {
        logic accept;
        logic load;
        logic calc;
        logic div_step;
        logic finish;
    } nbf_cmd_t;

    typedef struct packed {
        logic skip;
        logic emit;
        logic div_last;
        logic out_free;
    } nbf_sts_t;

endpackage

@@ sv/nbf_ram.sv @@
`timescale 1ns / 1ps
// Generic simple dual-port RAM with registered read.
module nbf_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end
endmodule

@@ sv/nbf_ctrl.sv @@
`timescale 1ns / 1ps
// Controller state machine sequencing the filter datapath.
module nbf_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  nbf_pkg::nbf_sts_t sts,
    output nbf_pkg::nbf_cmd_t cmd
);
    import nbf_pkg::*;

    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_LOAD   = 5'b00010,
        ST_CALC   = 5'b00100,
        ST_DIV    = 5'b01000,
        ST_FINISH = 5'b10000
    } state_t;

    state_t state_reg, state_next;

    assign s_ready      = (state_reg == ST_IDLE);
    assign cmd.accept   = s_valid && s_ready;
    assign cmd.load     = (state_reg == ST_LOAD);
    assign cmd.calc     = (state_reg == ST_CALC);
    assign cmd.div_step = (state_reg == ST_DIV);
    assign cmd.finish   = (state_reg == ST_FINISH) && sts.out_free;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (cmd.accept && !sts.skip) state_next = ST_LOAD;
            end
            ST_LOAD: begin
                state_next = sts.emit ? ST_CALC : ST_IDLE;
            end
            ST_CALC: begin
                state_next = ST_DIV;
            end
            ST_DIV: begin
                if (sts.div_last) state_next = ST_FINISH;
            end
            ST_FINISH: begin
                if (sts.out_free) state_next = ST_IDLE;
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end
endmodule

@@ sv/nbf_datapath.sv @@
`timescale 1ns / 1ps
// Datapath: line stores, window, position counters, tap sum, divider, output register.
module nbf_datapath #(
    parameter int MAX_WIDTH  = 256,
    parameter int PIXEL_BITS = 16
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  nbf_pkg::nbf_cmd_t                cmd,
    output nbf_pkg::nbf_sts_t                sts,
    input  logic                             cfg_wr_en,
    input  logic [nbf_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [nbf_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  logic [nbf_pkg::IN_PIX_W-1:0]     s_pixel_value,
    input  logic                             s_pad,
    output logic                             m_valid,
    input  logic                             m_ready,
    output logic [nbf_pkg::IN_PIX_W-1:0]     m_filtered_value,
    output logic                             m_row_end,
    output logic                             m_frame_end
);
    import nbf_pkg::*;

    localparam int ADDR_W = $clog2(MAX_WIDTH);
    localparam int CNT_W  = $clog2(MAX_WIDTH + 2);
    localparam int SUM_W  = PIXEL_BITS + 4;
    localparam int DCNT_W = $clog2(SUM_W + 1);

    // configuration
    logic [1:0]  mode_reg;
    logic [8:0]  fwidth_reg;
    logic [12:0] fheight_reg;

    logic [ADDR_W-1:0]     in_col_reg, out_col_reg;
    logic [ROW_W-1:0]      in_row_reg, out_row_reg;
    logic [CNT_W-1:0]      pend_reg;
    logic [PIXEL_BITS-1:0] pix_reg;
    logic [PIXEL_BITS-1:0] win_reg [9];

    logic [SUM_W-1:0]      dq_reg;
    logic [3:0]            rem_reg;
    logic [DIVISOR_W-1:0]  n_reg;
    logic [DCNT_W-1:0]     dcnt_reg;
    logic                  re_reg, fe_reg;

    logic [PIXEL_BITS-1:0] top_data, mid_data;

    // effective frame size
    logic [15:0]      fw_ext;
    logic [CNT_W-1:0] w_eff;
    logic [ROW_W-1:0] h_eff;
    logic             in_frame;

    assign fw_ext = {7'd0, fwidth_reg};
    always_comb begin
        if (fwidth_reg == 9'd0) begin
            w_eff = CNT_W'(1);
        end else if (fw_ext > 16'(MAX_WIDTH)) begin
            w_eff = CNT_W'(MAX_WIDTH);
        end else begin
            w_eff = CNT_W'(fw_ext);
        end
    end
    assign h_eff    = (fheight_reg == 13'd0) ? ROW_W'(1) : ROW_W'(fheight_reg);
    assign in_frame = in_row_reg < h_eff;

    logic [PIXEL_BITS+IN_PIX_W-1:0] pix_ext;
    assign pix_ext = {{PIXEL_BITS{1'b0}}, s_pixel_value};

    // line stores
    nbf_ram #(.WIDTH(PIXEL_BITS), .DEPTH(MAX_WIDTH)) u_line_prev (
        .clk     (aclk),
        .wr_en   (cmd.load),
        .wr_addr (in_col_reg),
        .wr_data (pix_reg),
        .rd_addr (in_col_reg),
        .rd_data (mid_data)
    );

    nbf_ram #(.WIDTH(PIXEL_BITS), .DEPTH(MAX_WIDTH)) u_line_prev2 (
        .clk     (aclk),
        .wr_en   (cmd.load),
        .wr_addr (in_col_reg),
        .wr_data (mid_data),
        .rd_addr (in_col_reg),
        .rd_data (top_data)
    );

    // edge tests on the output position
    logic [CNT_W-1:0] in_col_inc, out_col_inc;
    logic [ROW_W-1:0] out_row_inc;
    logic             col_first, col_last, row_first, row_last;

    assign in_col_inc  = CNT_W'(in_col_reg) + CNT_W'(1);
    assign out_col_inc = CNT_W'(out_col_reg) + CNT_W'(1);
    assign out_row_inc = out_row_reg + ROW_W'(1);
    assign col_first   = (out_col_reg == '0);
    assign col_last    = out_col_inc >= w_eff;
    assign row_first   = (out_row_reg == '0);
    assign row_last    = out_row_inc >= h_eff;

    // weighted tap sum
    logic [SUM_W-1:0]     tap_sum;
    logic [DIVISOR_W-1:0] tap_n;
    logic                 pass_centre;

    always_comb begin
        logic             en;
        logic [SUM_W-1:0] tv;
        tap_sum = '0;
        tap_n   = '0;
        for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 3; c++) begin
                en = !((r == 0) && row_first) && !((r == 2) && row_last) &&
                     !((c == 0) && col_first) && !((c == 2) && col_last);
                tv = SUM_W'(win_reg[r*3+c]);
                if (en) begin
                    if (mode_reg == MODE_GAUSS && r == 1 && c == 1) begin
                        tap_sum = tap_sum + (tv << 2);
                        tap_n   = tap_n + DIVISOR_W'(4);
                    end else if (mode_reg == MODE_GAUSS && (r == 1 || c == 1)) begin
                        tap_sum = tap_sum + (tv << 1);
                        tap_n   = tap_n + DIVISOR_W'(2);
                    end else begin
                        tap_sum = tap_sum + tv;
                        tap_n   = tap_n + DIVISOR_W'(1);
                    end
                end
            end
        end
    end
    assign pass_centre = (mode_reg == MODE_FILL) && (win_reg[4] != '0);

    // restoring divider step
    logic [4:0] rem_sh;
    logic       q_bit;
    assign rem_sh = {rem_reg, dq_reg[SUM_W-1]};
    assign q_bit  = rem_sh >= n_reg;

    logic [PIXEL_BITS+IN_PIX_W-1:0] q_ext;
    assign q_ext = {{IN_PIX_W{1'b0}}, dq_reg[PIXEL_BITS-1:0]};

    assign sts.skip     = s_pad && in_frame;
    assign sts.emit     = (pend_reg + CNT_W'(1)) > w_eff;
    assign sts.div_last = (dcnt_reg == DCNT_W'(1));
    assign sts.out_free = !m_valid || m_ready;

    logic cfg_hit;
    assign cfg_hit = cfg_wr_en &&
        (cfg_index == CFG_MODE || cfg_index == CFG_WIDTH || cfg_index == CFG_HEIGHT);

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg    <= MODE_BOX;
            fwidth_reg  <= WIDTH_RESET;
            fheight_reg <= HEIGHT_RESET;
            in_col_reg  <= '0;
            in_row_reg  <= '0;
            out_col_reg <= '0;
            out_row_reg <= '0;
            pend_reg    <= '0;
            dcnt_reg    <= '0;
            m_valid     <= 1'b0;
            for (int i = 0; i < 9; i++) win_reg[i] <= '0;
        end else begin
            if (cfg_hit) begin
                case (cfg_index)
                    CFG_MODE:   mode_reg    <= cfg_data[1:0];
                    CFG_WIDTH:  fwidth_reg  <= cfg_data[8:0];
                    CFG_HEIGHT: fheight_reg <= cfg_data;
                    default:    mode_reg    <= mode_reg;
                endcase
                in_col_reg  <= '0;
                in_row_reg  <= '0;
                out_col_reg <= '0;
                out_row_reg <= '0;
                pend_reg    <= '0;
            end
            if (cmd.load) begin
                for (int r = 0; r < 3; r++) begin
                    win_reg[r*3]   <= win_reg[r*3+1];
                    win_reg[r*3+1] <= win_reg[r*3+2];
                end
                win_reg[2] <= top_data;
                win_reg[5] <= mid_data;
                win_reg[8] <= pix_reg;
                if (in_col_inc >= w_eff) begin
                    in_col_reg <= '0;
                    in_row_reg <= in_row_reg + ROW_W'(1);
                end else begin
                    in_col_reg <= in_col_inc[ADDR_W-1:0];
                end
                pend_reg <= pend_reg + CNT_W'(1);
            end
            if (cmd.calc) begin
                dcnt_reg <= DCNT_W'(SUM_W);
                if (col_last && row_last) begin
                    in_col_reg  <= '0;
                    in_row_reg  <= '0;
                    out_col_reg <= '0;
                    out_row_reg <= '0;
                    pend_reg    <= '0;
                end else if (col_last) begin
                    out_col_reg <= '0;
                    out_row_reg <= out_row_inc;
                    pend_reg    <= pend_reg - CNT_W'(1);
                end else begin
                    out_col_reg <= out_col_inc[ADDR_W-1:0];
                    pend_reg    <= pend_reg - CNT_W'(1);
                end
            end
            if (cmd.div_step) begin
                dcnt_reg <= dcnt_reg - DCNT_W'(1);
            end
            if (cmd.finish) begin
                m_valid <= 1'b1;
            end else if (m_ready) begin
                m_valid <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            pix_reg <= in_frame ? pix_ext[PIXEL_BITS-1:0] : '0;
        end
        if (cmd.calc) begin
            dq_reg  <= pass_centre ? SUM_W'(win_reg[4]) : tap_sum;
            n_reg   <= pass_centre ? DIVISOR_W'(1) : tap_n;
            rem_reg <= '0;
            re_reg  <= col_last;
            fe_reg  <= col_last && row_last;
        end
        if (cmd.div_step) begin
            rem_reg <= q_bit ? 4'(rem_sh - n_reg) : rem_sh[3:0];
            dq_reg  <= {dq_reg[SUM_W-2:0], q_bit};
        end
        if (cmd.finish) begin
            m_filtered_value <= q_ext[IN_PIX_W-1:0];
            m_row_end        <= re_reg;
            m_frame_end      <= fe_reg;
        end
    end
endmodule

@@ sv/neighborhood_3x3_filter.sv @@
`timescale 1ns / 1ps
// Top level of the streaming 3x3 neighbourhood filter.
//
// Streaming 3x3 filter over raster-order pixels (box mean, 4-2-1 gaussian, or
// zero-pixel fill). One result per accepted pixel, one row plus one pixel
// late; pad requests flush the frame tail. A request that produces no result
// passes through accept and line store read (accept alone when a pad is
// ignored inside the frame). A request that produces a result passes through
// accept, line store read, tap sum, PIXEL_BITS+4 steps of the bit-serial
// divider, and the load of the output register. A finished result waits in the
// output register while the next request is taken. Writing any register
// restarts the frame; line stores keep their contents.
module neighborhood_3x3_filter #(
    parameter int MAX_WIDTH  = 256,
    parameter int PIXEL_BITS = 16
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    // configuration
    input  logic                           cfg_wr_en,
    input  logic [nbf_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [nbf_pkg::CFG_DATA_W-1:0] cfg_data,
    // pixel requests
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic [nbf_pkg::IN_PIX_W-1:0]   s_pixel_value,
    input  logic                           s_pad,
    // filtered pixels
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic [nbf_pkg::IN_PIX_W-1:0]   m_filtered_value,
    output logic                           m_row_end,
    output logic                           m_frame_end
);
    import nbf_pkg::*;

    nbf_cmd_t cmd;
    nbf_sts_t sts;

    // sequencing: idle, line read, sum, divide, output load
    nbf_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    nbf_datapath #(
        .MAX_WIDTH  (MAX_WIDTH),
        .PIXEL_BITS (PIXEL_BITS)
    ) u_datapath (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cmd              (cmd),
        .sts              (sts),
        .cfg_wr_en        (cfg_wr_en),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .s_pixel_value    (s_pixel_value),
        .s_pad            (s_pad),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_filtered_value (m_filtered_value),
        .m_row_end        (m_row_end),
        .m_frame_end      (m_frame_end)
    );
endmodule
